// ===== rtl/core/uart_keyword_suffix_matcher_unit_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the keyword suffix matcher
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// -----------------------------------------------------------------------------
`ifndef UART_KEYWORD_SUFFIX_MATCHER_UNIT_MACROS_SVH
`define UART_KEYWORD_SUFFIX_MATCHER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UKSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when cond holds, prop holds at the next edge.
`define UKSM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/uksm_pkg.sv =====
// -----------------------------------------------------------------------------
// Keyword suffix matcher package
// Shared types and the fixed command code table.
// -----------------------------------------------------------------------------
package uksm_pkg;

  localparam int unsigned WinChars = 8;
  localparam int unsigned WinW     = 8 * WinChars;
  localparam int unsigned CntW     = 32;
  localparam int unsigned NumCodes = 11;
  localparam int unsigned CmdW     = 4;

  // Window packing: oldest character in the top byte, newest in the bottom byte.
  typedef logic [WinW-1:0] window_t;

  // One chunk handed from the front to the back.
  typedef struct packed {
    window_t         window;
    logic [CntW-1:0] byte_total;
  } job_t;

  // Codes are right-aligned; the mask selects the characters a code covers.
  localparam window_t CodeText [NumCodes] = '{
    window_t'("TXWK00"),   window_t'("TXCLOLED"), window_t'("TXSAMOTO"),
    window_t'("TXRFOLED"), window_t'("TXSASEVO"), window_t'("TXSAMPU0"),
    window_t'("TXSOSYNO"), window_t'("TXSASYNO"), window_t'("TXSOMOTO"),
    window_t'("TXSOSEVO"), window_t'("TXSAVL00")
  };

  localparam window_t CodeMask [NumCodes] = '{
    64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
  };

endpackage

// ===== rtl/core/uksm_front.sv =====
// -----------------------------------------------------------------------------
// Keyword suffix matcher front end
// Normalizes each byte into the character window and counts bytes.
// -----------------------------------------------------------------------------
module uksm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          chunk_end_i,
  output logic                          job_push_o,
  output uksm_pkg::job_t                job_o
);

  localparam logic [7:0] ChZero = 8'h30;

  uksm_pkg::window_t             win_q, win_d;
  logic [uksm_pkg::CntW-1:0]     bytes_q, bytes_d;
  logic [7:0]                    ch;

  // Fold lower case letters to upper case.
  assign ch = (rx_byte_i inside {[8'h61:8'h7A]}) ? (rx_byte_i - 8'h20) : rx_byte_i;

  always_comb begin
    win_d = win_q;
    if (rx_byte_i == 8'h00) begin
      win_d = {win_q[uksm_pkg::WinW-17:0], ChZero, ChZero};
    end else if (rx_byte_i inside {[8'h21:8'h7E]}) begin
      win_d = {win_q[uksm_pkg::WinW-9:0], ch};
    end
    bytes_d = bytes_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      bytes_q <= '0;
    end else if (accept_i) begin
      win_q   <= win_d;
      bytes_q <= bytes_d;
    end
  end

  assign job_push_o        = accept_i && chunk_end_i;
  assign job_o.window      = win_d;
  assign job_o.byte_total  = bytes_d;

endmodule

// ===== rtl/core/uksm_queue.sv =====
// -----------------------------------------------------------------------------
// Keyword suffix matcher job queue
// Small register queue that decouples the front end from the matcher.
// -----------------------------------------------------------------------------
module uksm_queue #(
  parameter int unsigned QDepth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  uksm_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output uksm_pkg::job_t job_o
);

  localparam int unsigned IdxW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

  uksm_pkg::job_t      mem_q [QDepth];
  logic [IdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastIdx) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LastIdx) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

endmodule

// ===== rtl/core/uksm_back.sv =====
// -----------------------------------------------------------------------------
// Keyword suffix matcher back end
// Compares a chunk's window with the code table and keeps the chunk counters.
// -----------------------------------------------------------------------------
module uksm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  uksm_pkg::job_t                 job_i,
  output logic                           job_pop_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic                           matched_o,
  output logic [uksm_pkg::CmdW-1:0]      command_o,
  output logic [uksm_pkg::CntW-1:0]      chunk_total_o,
  output logic [uksm_pkg::CntW-1:0]      byte_total_o,
  output logic [uksm_pkg::CntW-1:0]      match_total_o,
  output logic [uksm_pkg::CntW-1:0]      miss_total_o
);

  logic                           out_valid_q;
  logic                           take;
  logic                           hit;
  logic [uksm_pkg::CmdW-1:0]      cmd;
  logic [uksm_pkg::CntW-1:0]      chunk_q, match_q, miss_q;
  logic [uksm_pkg::CntW-1:0]      chunk_d, match_d, miss_d;
  logic                           matched_q;
  logic [uksm_pkg::CmdW-1:0]      command_q;
  logic [uksm_pkg::CntW-1:0]      byte_q;

  // Take a job when the result slot is free or is being emptied this cycle.
  assign take      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = take;

  // Walk the table from the top so the lowest matching index wins.
  always_comb begin
    hit = 1'b0;
    cmd = '0;
    for (int i = uksm_pkg::NumCodes - 1; i >= 0; i--) begin
      if ((job_i.window & uksm_pkg::CodeMask[i]) == uksm_pkg::CodeText[i]) begin
        hit = 1'b1;
        cmd = uksm_pkg::CmdW'(i);
      end
    end
    chunk_d = chunk_q + 1'b1;
    match_d = hit ? match_q + 1'b1 : match_q;
    miss_d  = hit ? miss_q : miss_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chunk_q     <= '0;
      match_q     <= '0;
      miss_q      <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        chunk_q     <= chunk_d;
        match_q     <= match_d;
        miss_q      <= miss_d;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      matched_q <= hit;
      command_q <= cmd;
      byte_q    <= job_i.byte_total;
    end
  end

  assign empty_o       = !out_valid_q;
  assign matched_o     = matched_q;
  assign command_o     = command_q;
  assign chunk_total_o = chunk_q;
  assign byte_total_o  = byte_q;
  assign match_total_o = match_q;
  assign miss_total_o  = miss_q;

endmodule

// ===== rtl/core/uart_keyword_suffix_matcher_unit.sv =====
// A chunk-ending byte is written into the job queue, then taken into the result slot once the slot is free.
// Throughput: one byte per cycle while the job queue is not full; one result per cycle while pop keeps up.
// The job queue (QDepth entries) sets how many chunk ends can wait on a stalled result side.
// Reset clears the character window, all counters, the queue and the result slot.
// -----------------------------------------------------------------------------
// Keyword suffix matcher top level
// Normalizes received bytes into an eight-character window and, at each chunk
// end, reports which command code the window ends with, plus running totals.
// -----------------------------------------------------------------------------
`include "uart_keyword_suffix_matcher_unit_macros.svh"

module uart_keyword_suffix_matcher_unit #(
  parameter int unsigned QDepth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           chunk_end_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           matched_o,
  output logic [uksm_pkg::CmdW-1:0]      command_o,
  output logic [uksm_pkg::CntW-1:0]      chunk_total_o,
  output logic [uksm_pkg::CntW-1:0]      byte_total_o,
  output logic [uksm_pkg::CntW-1:0]      match_total_o,
  output logic [uksm_pkg::CntW-1:0]      miss_total_o
);

  // A beat is taken whenever the job queue has room. Bytes that do not end a
  // chunk only update the window and the byte count, so they never fill the
  // queue; the queue is what lets the front keep going while a result waits.
  logic           accept;
  logic           job_push;
  uksm_pkg::job_t job_in;
  logic           job_valid;
  logic           job_pop;
  uksm_pkg::job_t job_out;

  assign accept = push && !full;

  // Front end: character normalization, window shift and byte counter.
  uksm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .chunk_end_i (chunk_end_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  // Each chunk end carries a snapshot of the updated window and byte count.
  uksm_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .job_o   (job_out)
  );

  // Back end: table compare, chunk/match/miss counters and the result slot.
  uksm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .matched_o     (matched_o),
    .command_o     (command_o),
    .chunk_total_o (chunk_total_o),
    .byte_total_o  (byte_total_o),
    .match_total_o (match_total_o),
    .miss_total_o  (miss_total_o)
  );

  // Every reported chunk is counted as exactly one match or one miss.
  `UKSM_ASSERT(a_totals_add_up, empty || ((match_total_o + miss_total_o) == chunk_total_o), "match and miss totals do not add up to the chunk total")
  // A miss always reports command zero.
  `UKSM_ASSERT(a_miss_cmd_zero, empty || matched_o || (command_o == '0), "miss reported with a nonzero command")
  // Command indexes stay inside the table.
  `UKSM_ASSERT(a_cmd_range, empty || (command_o < uksm_pkg::CmdW'(uksm_pkg::NumCodes)), "command index beyond the code table")
  // Delivering a result while another chunk waits moves the chunk total on by one.
  `UKSM_ASSERT_NEXT(a_chunk_step, pop && !empty && job_valid, chunk_total_o == ($past(chunk_total_o) + 1'b1), "chunk total did not advance by one")

endmodule
